>>> rtl/pmva_pkg.sv
// pmva_pkg: constants, arctangent table and shared types for the polar
// momentum vector add unit. No dependencies.
`timescale 1ns / 1ps

package pmva_pkg;

   localparam int MAX_STEPS = 32;
   localparam logic [15:0] ANG_FULL = 16'd46080;
   localparam logic [15:0] ANG_QUARTER = 16'd11520;
   localparam logic [29:0] INV_GAIN = 30'd652032874;
   localparam logic signed [31:0] DEG180_Q16 = 32'sd11796480;
   localparam logic signed [31:0] DEG360_Q16 = 32'sd23592960;
   localparam logic signed [25:0] COMP_MAX = 26'sd33554430;
   localparam logic [24:0] MAG_MAX = 25'd33554431;

   // rotation CORDIC datapath: Q16.16 scaled magnitude plus growth
   localparam int RW = 44;
   // vectoring datapath: 26-bit component * 16 plus growth
   localparam int VW = 34;
   localparam int ZW = 32;

   typedef logic signed [RW-1:0] rot_word_type;
   typedef logic signed [VW-1:0] vec_word_type;
   typedef logic signed [ZW-1:0] ang_word_type;

   typedef struct packed {
      rot_word_type ax;
      rot_word_type ay;
      ang_word_type az;
      rot_word_type bx;
      rot_word_type by;
      ang_word_type bz;
   } rot_cell_type;

   typedef struct packed {
      vec_word_type x;
      vec_word_type y;
      ang_word_type z;
   } vec_cell_type;

   function automatic ang_word_type atan_q16(input int idx);
      ang_word_type v;
      v = '0;
      unique case (idx)
         0: v = 32'sd2949120;
         1: v = 32'sd1740967;
         2: v = 32'sd919879;
         3: v = 32'sd466945;
         4: v = 32'sd234379;
         5: v = 32'sd117304;
         6: v = 32'sd58666;
         7: v = 32'sd29335;
         8: v = 32'sd14668;
         9: v = 32'sd7334;
         10: v = 32'sd3667;
         11: v = 32'sd1833;
         12: v = 32'sd917;
         13: v = 32'sd458;
         14: v = 32'sd229;
         15: v = 32'sd115;
         16: v = 32'sd57;
         17: v = 32'sd29;
         18: v = 32'sd14;
         19: v = 32'sd7;
         20: v = 32'sd4;
         21: v = 32'sd2;
         22: v = 32'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/polar_momentum_vector_add_unit.sv
// polar_momentum_vector_add_unit: top level, a fixed pipeline of CORDIC
// and divider cells. Depends on pmva_pkg, pmva_rot_cell, pmva_vec_cell,
// pmva_div_cell.
//
// Usage: raise start with the req_ fields for one cycle per transfer; busy
// is held low, so a transfer may be offered in every cycle. Each transfer
// yields one result that appears on the rsp_ ports for one cycle with
// rsp_valid high, in order. Pipeline stages, N = min(CORDIC_ITERATIONS, 32):
//   1 magnitude multiply, 1 prescale, N rotation cells, 1 round/quadrant,
//   1 sum/clamp, 1 fold, N vectoring cells, 2 post-scale multiply, 1 round,
//   33 divider cells. Throughput is one item per cycle, since every cell
// takes a new transfer in each cycle; the chain lengths set only the latency.
// Reset clears only the valid pipe; data in flight is dropped. The receiver
// cannot stall; results are never held.
`timescale 1ns / 1ps

module polar_momentum_vector_add_unit #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_a_angle,
   input  logic [15:0]        req_a_speed,
   input  logic [15:0]        req_a_mass,
   input  logic [23:0]        req_a_magnitude,
   input  logic [15:0]        req_b_angle,
   input  logic [15:0]        req_b_speed,
   input  logic [15:0]        req_b_mass,
   input  logic [23:0]        req_b_magnitude,
   input  logic               req_use_given_magnitude,
   output logic               rsp_valid,
   output logic signed [25:0] rsp_sum_x,
   output logic signed [25:0] rsp_sum_y,
   output logic [15:0]        rsp_sum_angle,
   output logic [24:0]        rsp_sum_magnitude,
   output logic [15:0]        rsp_sum_speed
);

   localparam int N = (CORDIC_ITERATIONS > pmva_pkg::MAX_STEPS) ?
                      pmva_pkg::MAX_STEPS : CORDIC_ITERATIONS;
   localparam int DIVS = 33;
   localparam int LAT = 2 * N + 8 + DIVS;
   localparam int RW = pmva_pkg::RW;
   localparam int VW = pmva_pkg::VW;

   // ---------------- valid pipe
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[LAT-2:0], start};
   end
   assign busy = 1'b0;
   assign rsp_valid = vld_ff[LAT-1];

   // ---------------- stage 0: magnitudes, angle reduce
   logic [23:0] mag_a_ff, mag_b_ff;
   logic [15:0] ang_a_ff, ang_b_ff;
   logic [31:0] prod_a, prod_b;
   assign prod_a = req_a_speed * req_a_mass;
   assign prod_b = req_b_speed * req_b_mass;

   function automatic logic [15:0] reduce(input logic [15:0] a);
      return (a >= pmva_pkg::ANG_FULL) ? 16'(a - pmva_pkg::ANG_FULL) : a;
   endfunction

   // first mass travels alongside for the divider
   logic [15:0] mass_pipe_ff [2*N+8];

   always_ff @(posedge clock) begin
      mag_a_ff <= req_use_given_magnitude ? req_a_magnitude : prod_a[31:8];
      mag_b_ff <= req_use_given_magnitude ? req_b_magnitude : prod_b[31:8];
      ang_a_ff <= reduce(req_a_angle);
      ang_b_ff <= reduce(req_b_angle);
      mass_pipe_ff[0] <= req_a_mass;
      for (int k = 1; k < 2*N+8; k++) mass_pipe_ff[k] <= mass_pipe_ff[k-1];
   end

   // ---------------- stage 1: scale by 1/K, quadrant split
   function automatic logic [1:0] quad(input logic [15:0] a);
      logic [1:0] q;
      q = 2'd3;
      if (a < pmva_pkg::ANG_QUARTER) q = 2'd0;
      else if (a < 16'd23040) q = 2'd1;
      else if (a < 16'd34560) q = 2'd2;
      return q;
   endfunction

   function automatic logic [15:0] remq(input logic [15:0] a, input logic [1:0] q);
      return 16'(a - 16'(q * pmva_pkg::ANG_QUARTER));
   endfunction

   logic [53:0] scl_a, scl_b;
   logic [1:0]  qa_a, qa_b;
   assign scl_a = mag_a_ff * pmva_pkg::INV_GAIN;
   assign scl_b = mag_b_ff * pmva_pkg::INV_GAIN;
   assign qa_a = quad(ang_a_ff);
   assign qa_b = quad(ang_b_ff);

   pmva_pkg::rot_cell_type rot_chain [N+1];
   logic [1:0] qa_pipe_ff [N+1];
   logic [1:0] qb_pipe_ff [N+1];

   always_ff @(posedge clock) begin
      rot_chain[0].ax <= RW'(scl_a[53:22]);
      rot_chain[0].ay <= '0;
      rot_chain[0].az <= 32'(remq(ang_a_ff, qa_a)) <<< 9;
      rot_chain[0].bx <= RW'(scl_b[53:22]);
      rot_chain[0].by <= '0;
      rot_chain[0].bz <= 32'(remq(ang_b_ff, qa_b)) <<< 9;
      qa_pipe_ff[0] <= qa_a;
      qb_pipe_ff[0] <= qa_b;
      for (int k = 1; k <= N; k++) begin
         qa_pipe_ff[k] <= qa_pipe_ff[k-1];
         qb_pipe_ff[k] <= qb_pipe_ff[k-1];
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_rot
      pmva_rot_cell #(.STEP(g)) u_cell (
         .clock(clock), .d_in(rot_chain[g]), .d_out(rot_chain[g+1])
      );
   end

   // ---------------- round + quadrant
   function automatic logic signed [27:0] rnd8(input logic signed [RW-1:0] v);
      logic signed [RW-1:0] t;
      t = v + RW'(128);
      return 28'(t >>> 8);
   endfunction

   logic signed [27:0] cxa, sya, cxb, syb;
   logic signed [27:0] ox_a_ff, oy_a_ff, ox_b_ff, oy_b_ff;
   assign cxa = rnd8(rot_chain[N].ax);
   assign sya = rnd8(rot_chain[N].ay);
   assign cxb = rnd8(rot_chain[N].bx);
   assign syb = rnd8(rot_chain[N].by);

   always_ff @(posedge clock) begin
      unique case (qa_pipe_ff[N])
         2'd0: begin ox_a_ff <= cxa; oy_a_ff <= sya; end
         2'd1: begin ox_a_ff <= -sya; oy_a_ff <= cxa; end
         2'd2: begin ox_a_ff <= -cxa; oy_a_ff <= -sya; end
         default: begin ox_a_ff <= sya; oy_a_ff <= -cxa; end
      endcase
      unique case (qb_pipe_ff[N])
         2'd0: begin ox_b_ff <= cxb; oy_b_ff <= syb; end
         2'd1: begin ox_b_ff <= -syb; oy_b_ff <= cxb; end
         2'd2: begin ox_b_ff <= -cxb; oy_b_ff <= -syb; end
         default: begin ox_b_ff <= syb; oy_b_ff <= -cxb; end
      endcase
   end

   // ---------------- sum and clamp
   function automatic logic signed [25:0] clamp(input logic signed [28:0] v);
      logic signed [25:0] r;
      if (v > 29'(pmva_pkg::COMP_MAX)) r = pmva_pkg::COMP_MAX;
      else if (v < -29'(pmva_pkg::COMP_MAX)) r = -pmva_pkg::COMP_MAX;
      else r = 26'(v);
      return r;
   endfunction

   logic signed [25:0] sx_ff, sy_ff;
   always_ff @(posedge clock) begin
      sx_ff <= clamp(29'(ox_a_ff) + 29'(ox_b_ff));
      sy_ff <= clamp(29'(oy_a_ff) + 29'(oy_b_ff));
   end

   // ---------------- fold into right half plane
   pmva_pkg::vec_cell_type vec_chain [N+1];
   logic signed [25:0] sx_pipe_ff [N+4+DIVS];
   logic signed [25:0] sy_pipe_ff [N+4+DIVS];
   logic               nz_pipe_ff [N+3];

   always_ff @(posedge clock) begin
      if (sx_ff < 0) begin
         vec_chain[0].x <= -(VW'(sx_ff) <<< 4);
         vec_chain[0].y <= -(VW'(sy_ff) <<< 4);
         vec_chain[0].z <= pmva_pkg::DEG180_Q16;
      end else begin
         vec_chain[0].x <= VW'(sx_ff) <<< 4;
         vec_chain[0].y <= VW'(sy_ff) <<< 4;
         vec_chain[0].z <= '0;
      end
      sx_pipe_ff[0] <= sx_ff;
      sy_pipe_ff[0] <= sy_ff;
      nz_pipe_ff[0] <= (sx_ff != 0) || (sy_ff != 0);
      for (int k = 1; k < N+4+DIVS; k++) begin
         sx_pipe_ff[k] <= sx_pipe_ff[k-1];
         sy_pipe_ff[k] <= sy_pipe_ff[k-1];
      end
      for (int k = 1; k < N+3; k++) nz_pipe_ff[k] <= nz_pipe_ff[k-1];
   end

   for (genvar g = 0; g < N; g++) begin : g_vec
      pmva_vec_cell #(.STEP(g)) u_cell (
         .clock(clock), .d_in(vec_chain[g]), .d_out(vec_chain[g+1])
      );
   end

   // ---------------- angle fold, magnitude multiply (split in two halves)
   logic signed [31:0] t_wrap;
   logic signed [31:0] t_rnd;
   logic [15:0]        ang_ff, ang2_ff, ang_out_ff;
   logic [17:0]        xlo_ff;
   logic [VW-19:0]     xhi_ff;
   logic [47:0]        plo_ff;
   logic [47:0]        phi_ff;
   logic [15:0]        ang_nx;

   always_comb begin
      t_wrap = vec_chain[N].z;
      if (t_wrap < 0) t_wrap = t_wrap + pmva_pkg::DEG360_Q16;
      t_rnd = (t_wrap + 32'sd256) >>> 9;
      if (t_rnd >= 32'(pmva_pkg::ANG_FULL)) t_rnd = t_rnd - 32'(pmva_pkg::ANG_FULL);
      if (t_rnd < 0) t_rnd = '0;
      ang_nx = t_rnd[15:0];
   end

   always_ff @(posedge clock) begin
      ang_ff <= ang_nx;
      xlo_ff <= vec_chain[N].x[17:0];
      xhi_ff <= vec_chain[N].x[VW-1:18];
      // partial products: X = hi*2^18 + lo, X kept nonnegative by the fold
      plo_ff <= 48'(xlo_ff) * 48'(pmva_pkg::INV_GAIN);
      phi_ff <= 48'(xhi_ff) * 48'(pmva_pkg::INV_GAIN);
      ang2_ff <= ang_ff;
   end

   // ---------------- round magnitude
   logic [66:0] prod_full;
   logic [32:0] m_raw;
   logic [24:0] mag_nx;
   assign prod_full = (67'(phi_ff) << 18) + 67'(plo_ff) + (67'd1 << 33);
   assign m_raw = prod_full[66:34];
   assign mag_nx = (!nz_pipe_ff[N+2]) ? 25'd0 :
                   (m_raw > 33'(pmva_pkg::MAG_MAX)) ? pmva_pkg::MAG_MAX : m_raw[24:0];

   logic [24:0] mag_ff;
   always_ff @(posedge clock) begin
      mag_ff <= mag_nx;
      ang_out_ff <= nz_pipe_ff[N+2] ? ang2_ff : 16'd0;
   end

   // ---------------- divider chain: (mag << 8) / mass
   logic [16:0] d_rem  [DIVS+1];
   logic [32:0] d_num  [DIVS+1];
   logic [15:0] d_den  [DIVS+1];
   logic [32:0] d_quo  [DIVS+1];
   logic [15:0] ang_dpipe_ff [DIVS];
   logic [24:0] mag_dpipe_ff [DIVS];

   assign d_rem[0] = '0;
   assign d_num[0] = {mag_ff, 8'd0};
   assign d_den[0] = mass_pipe_ff[2*N+7];
   assign d_quo[0] = '0;

   for (genvar g = 0; g < DIVS; g++) begin : g_div
      pmva_div_cell u_cell (
         .clock(clock),
         .rem_in(d_rem[g]), .num_in(d_num[g]), .den_in(d_den[g]), .quo_in(d_quo[g]),
         .rem_out(d_rem[g+1]), .num_out(d_num[g+1]), .den_out(d_den[g+1]),
         .quo_out(d_quo[g+1])
      );
   end

   always_ff @(posedge clock) begin
      ang_dpipe_ff[0] <= ang_out_ff;
      mag_dpipe_ff[0] <= mag_ff;
      for (int k = 1; k < DIVS; k++) begin
         ang_dpipe_ff[k] <= ang_dpipe_ff[k-1];
         mag_dpipe_ff[k] <= mag_dpipe_ff[k-1];
      end
   end

   // zero mass yields all-ones quotient, which saturates as required
   assign rsp_sum_speed = (d_quo[DIVS] > 33'd65535) ? 16'hFFFF : d_quo[DIVS][15:0];
   assign rsp_sum_angle = ang_dpipe_ff[DIVS-1];
   assign rsp_sum_magnitude = mag_dpipe_ff[DIVS-1];
   assign rsp_sum_x = sx_pipe_ff[N+3+DIVS];
   assign rsp_sum_y = sy_pipe_ff[N+3+DIVS];

   // ---------------- checks
   a_busy_low: assert property (@(posedge clock) !busy)
      else $error("busy asserted");
   a_valid_follows: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |=> vld_ff[1])
      else $error("valid pipe lost a transfer");
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sum_angle < pmva_pkg::ANG_FULL)
      else $error("angle out of range");
   a_zero_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sum_x == 0 && rsp_sum_y == 0) |->
      (rsp_sum_magnitude == 0 && rsp_sum_angle == 0))
      else $error("zero sum gave nonzero polar result");

endmodule

>>> rtl/pmva_rot_cell.sv
// pmva_rot_cell: one rotation-mode CORDIC step for both input vectors.
// Depends on pmva_pkg.
`timescale 1ns / 1ps

module pmva_rot_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  pmva_pkg::rot_cell_type d_in,
   output pmva_pkg::rot_cell_type d_out
);

   pmva_pkg::rot_cell_type cell_ff, cell_in;

   always_comb begin
      cell_in = d_in;
      if (d_in.az >= 0) begin
         cell_in.ax = d_in.ax - (d_in.ay >>> STEP);
         cell_in.ay = d_in.ay + (d_in.ax >>> STEP);
         cell_in.az = d_in.az - pmva_pkg::atan_q16(STEP);
      end else begin
         cell_in.ax = d_in.ax + (d_in.ay >>> STEP);
         cell_in.ay = d_in.ay - (d_in.ax >>> STEP);
         cell_in.az = d_in.az + pmva_pkg::atan_q16(STEP);
      end
      if (d_in.bz >= 0) begin
         cell_in.bx = d_in.bx - (d_in.by >>> STEP);
         cell_in.by = d_in.by + (d_in.bx >>> STEP);
         cell_in.bz = d_in.bz - pmva_pkg::atan_q16(STEP);
      end else begin
         cell_in.bx = d_in.bx + (d_in.by >>> STEP);
         cell_in.by = d_in.by - (d_in.bx >>> STEP);
         cell_in.bz = d_in.bz + pmva_pkg::atan_q16(STEP);
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign d_out = cell_ff;

endmodule

>>> rtl/pmva_vec_cell.sv
// pmva_vec_cell: one vectoring-mode CORDIC step on the summed vector.
// Depends on pmva_pkg.
`timescale 1ns / 1ps

module pmva_vec_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  pmva_pkg::vec_cell_type d_in,
   output pmva_pkg::vec_cell_type d_out
);

   pmva_pkg::vec_cell_type cell_ff, cell_in;

   always_comb begin
      cell_in = d_in;
      if (d_in.y > 0) begin
         cell_in.x = d_in.x + (d_in.y >>> STEP);
         cell_in.y = d_in.y - (d_in.x >>> STEP);
         cell_in.z = d_in.z + pmva_pkg::atan_q16(STEP);
      end else begin
         cell_in.x = d_in.x - (d_in.y >>> STEP);
         cell_in.y = d_in.y + (d_in.x >>> STEP);
         cell_in.z = d_in.z - pmva_pkg::atan_q16(STEP);
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign d_out = cell_ff;

endmodule

>>> rtl/pmva_div_cell.sv
// pmva_div_cell: one restoring-division step of magnitude / first mass.
// Self-contained; used by the top level as a chain of cells.
`timescale 1ns / 1ps

module pmva_div_cell (
   input  logic        clock,
   input  logic [16:0] rem_in,
   input  logic [32:0] num_in,
   input  logic [15:0] den_in,
   input  logic [32:0] quo_in,
   output logic [16:0] rem_out,
   output logic [32:0] num_out,
   output logic [15:0] den_out,
   output logic [32:0] quo_out
);

   logic [17:0] trial;
   logic [16:0] rem_ff, rem_nx;
   logic [32:0] num_ff, quo_ff;
   logic [15:0] den_ff;
   logic        fits;

   always_comb begin
      trial = {rem_in, num_in[32]};
      fits = trial >= {2'b00, den_in};
      rem_nx = fits ? 17'(trial - {2'b00, den_in}) : trial[16:0];
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_nx;
      num_ff <= {num_in[31:0], 1'b0};
      den_ff <= den_in;
      quo_ff <= {quo_in[31:0], fits};
   end

   assign rem_out = rem_ff;
   assign num_out = num_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;

endmodule
